// File: sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds request codes, register indexes, field widths and cell layout.
// No dependencies.
package tcw_pkg;

    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int CELL_W  = CHAR_W + 2 * COLOR_W;
    localparam int POS_W   = 11;
    localparam int REQ_W   = 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - POS_W - CELL_W - 1;
    localparam int IN_PAD_W    = IN_TDATA_W - CHAR_W - POS_W;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [COLOR_W-1:0] FG_RESET     = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET     = 4'h0;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [0:0] {
        CFG_FG = 1'b0,
        CFG_BG = 1'b1
    } cfg_reg_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCROLL = 6'b000010,
        S_FILL   = 6'b000100,
        S_CLEAR  = 6'b001000,
        S_RDWAIT = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

endpackage

// File: sv/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the screen cell store. No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/tcw_cursor.sv
// Cursor tracker: cell index plus column counter, advance and newline handling.
// Flags wrap past the last cell and returns the scrolled-back position.
// Depends on nothing beyond its parameters.
module tcw_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             newline,
    output logic [$clog2(ROWS*COLUMNS)-1:0]  cursor,
    output logic [$clog2(ROWS*COLUMNS)-1:0]  cursor_new,
    output logic                             wrap
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = AW + 1;
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    logic [AW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] col_reg, col_next;
    logic [IW-1:0] sum;
    logic [IW-1:0] moved;

    always_comb
    begin
        if (newline)
        begin
            sum = {1'b0, cursor_reg} + IW'(COLUMNS) - IW'(col_reg);
        end
        else
        begin
            sum = {1'b0, cursor_reg} + IW'(1);
        end
        wrap  = (sum >= IW'(CELLS));
        moved = wrap ? (sum - IW'(COLUMNS)) : sum;

        cursor_next = cursor_reg;
        col_next    = col_reg;
        if (advance)
        begin
            cursor_next = moved[AW-1:0];
            if (newline || (col_reg == CW'(COLUMNS - 1)))
            begin
                col_next = '0;
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            col_reg    <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
        end
    end

    assign cursor     = cursor_reg;
    assign cursor_new = cursor_next;

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cursor_reg) < CELLS) && (int'(col_reg) < COLUMNS))
        else $error("cursor or column out of range");

endmodule

// File: sv/text_console_writer.sv
// Text console writer: screen cell store in one RAM, cursor tracker and sequencer.
// Depends on tcw_pkg, tcw_ram and tcw_cursor.
//
// A put without scroll or an unused code registers its result to the output; a read
// waits in S_RDWAIT for the RAM; a scroll copies rows through the RAM port, then fills
// blanks; a clear writes one cell per cycle. One request in flight at a time.
// Throughput: one put per cycle while results are taken and no scroll is running.
// Reset: cursor 0, fg 15, bg 0; cell contents undefined until cleared or written.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic [tcw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] req_type
    input  logic [tcw_pkg::REQ_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [10:0] cursor_pos, [26:11] read_data, [27] scrolled, rest zero
    output logic [tcw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [0:0]                         cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]        cfg_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = AW + 1;

    tcw_pkg::state_t state_reg, state_next;
    tcw_pkg::req_t   req;

    logic [tcw_pkg::COLOR_W-1:0] fg_reg, fg_next, bg_reg, bg_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic                        range_ok_reg, range_ok_next;
    logic                        pend_scr_reg, pend_scr_next;
    logic [tcw_pkg::CELL_W-1:0]  pend_data_reg, pend_data_next;
    logic                        out_valid_reg, out_valid_next;
    logic [tcw_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [tcw_pkg::CHAR_W-1:0] char_code;
    logic [tcw_pkg::POS_W-1:0]  cell_index;
    logic                       accept, out_free, is_newline, in_range;
    logic [AW-1:0]              cursor, cursor_new;
    logic                       wrap, cur_advance;
    logic [tcw_pkg::CELL_W-1:0] blank, put_cell;

    logic                       wr_en, rd_en;
    logic [AW-1:0]              wr_addr, rd_addr;
    logic [tcw_pkg::CELL_W-1:0] wr_data, rd_data;
    logic [IW-1:0]              scroll_dst;

    assign req        = tcw_pkg::req_t'(s_axis_tuser);
    assign char_code  = s_axis_tdata[tcw_pkg::CHAR_W-1:0];
    assign cell_index = s_axis_tdata[tcw_pkg::CHAR_W +: tcw_pkg::POS_W];
    assign is_newline = (char_code == tcw_pkg::NEWLINE_CODE);
    assign in_range   = (int'(cell_index) < CELLS);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == tcw_pkg::S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cur_advance   = accept && (req == tcw_pkg::REQ_PUT);
    assign cfg_ready     = 1'b1;

    assign blank      = {bg_reg, fg_reg, {tcw_pkg::CHAR_W{1'b0}}};
    assign put_cell   = {bg_reg, fg_reg, char_code};
    assign scroll_dst = idx_reg - IW'(COLUMNS + 1);

    tcw_cursor #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (cur_advance),
        .newline   (is_newline),
        .cursor    (cursor),
        .cursor_new(cursor_new),
        .wrap      (wrap)
    );

    tcw_ram #(
        .WIDTH(tcw_pkg::CELL_W),
        .DEPTH(CELLS)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // RAM port muxing per state
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = blank;
        rd_en   = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        case (state_reg)
            tcw_pkg::S_IDLE:
            begin
                wr_en   = accept && (req == tcw_pkg::REQ_PUT) && !is_newline;
                wr_addr = cursor;
                wr_data = put_cell;
                rd_en   = accept && (req == tcw_pkg::REQ_READ) && in_range;
                rd_addr = AW'(cell_index);
            end
            tcw_pkg::S_SCROLL:
            begin
                // read one row ahead, write back what the last read returned
                rd_en   = (idx_reg < IW'(CELLS));
                wr_en   = (idx_reg > IW'(COLUMNS));
                wr_addr = scroll_dst[AW-1:0];
                wr_data = rd_data;
            end
            tcw_pkg::S_FILL, tcw_pkg::S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        range_ok_next  = range_ok_reg;
        pend_scr_next  = pend_scr_reg;
        pend_data_next = pend_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == tcw_pkg::CFG_FG)
            begin
                fg_next = cfg_data;
            end
            else
            begin
                bg_next = cfg_data;
            end
        end

        case (state_reg)
            tcw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    pend_data_next = '0;
                    pend_scr_next  = 1'b0;
                    case (req)
                        tcw_pkg::REQ_PUT:
                        begin
                            if (wrap)
                            begin
                                pend_scr_next = 1'b1;
                                idx_next      = IW'(COLUMNS);
                                state_next    = tcw_pkg::S_SCROLL;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = {{tcw_pkg::OUT_PAD_W{1'b0}}, 1'b0,
                                                  {tcw_pkg::CELL_W{1'b0}},
                                                  tcw_pkg::POS_W'(cursor_new)};
                            end
                        end
                        tcw_pkg::REQ_CLEAR:
                        begin
                            idx_next   = '0;
                            state_next = tcw_pkg::S_CLEAR;
                        end
                        tcw_pkg::REQ_READ:
                        begin
                            range_ok_next = in_range;
                            state_next    = tcw_pkg::S_RDWAIT;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = {{tcw_pkg::OUT_PAD_W{1'b0}}, 1'b0,
                                              {tcw_pkg::CELL_W{1'b0}},
                                              tcw_pkg::POS_W'(cursor)};
                        end
                    endcase
                end
            end
            tcw_pkg::S_SCROLL:
            begin
                if (idx_reg == IW'(CELLS))
                begin
                    idx_next   = IW'(CELLS - COLUMNS);
                    state_next = tcw_pkg::S_FILL;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            tcw_pkg::S_FILL, tcw_pkg::S_CLEAR:
            begin
                if (idx_reg == IW'(CELLS - 1))
                begin
                    state_next = tcw_pkg::S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            tcw_pkg::S_RDWAIT:
            begin
                pend_data_next = range_ok_reg ? rd_data : '0;
                state_next     = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{tcw_pkg::OUT_PAD_W{1'b0}}, pend_scr_reg,
                                      pend_data_reg, tcw_pkg::POS_W'(cursor)};
                    state_next     = tcw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            fg_reg        <= tcw_pkg::FG_RESET;
            bg_reg        <= tcw_pkg::BG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        range_ok_reg  <= range_ok_next;
        pend_scr_reg  <= pend_scr_next;
        pend_data_reg <= pend_data_next;
        out_data_reg  <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_no_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write of the same cell in one cycle");

    a_wrap_scrolls: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req == tcw_pkg::REQ_PUT) && wrap) |=> (state_reg == tcw_pkg::S_SCROLL))
        else $error("cursor wrap did not start a scroll");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != tcw_pkg::S_IDLE) && (state_reg != tcw_pkg::S_DONE)) |=>
        !$rose(m_axis_tvalid))
        else $error("result issued while a request is still in progress");

endmodule

// File: test/text_console_writer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer: request stream in, cursor/cell results out.
// Depends on tcw_pkg and the text_console_writer RTL; a scoreboard class tracks the screen.
module text_console_writer_tb;

    localparam int COLS            = 80;
    localparam int ROWS            = 25;
    localparam int CELLS           = COLS * ROWS;
    localparam int MAX_INDEX       = 2 ** tcw_pkg::POS_W - 1;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int LONG_HOLD       = 500;
    // Worst case: every request a full-screen scroll or clear, plus stalls.
    localparam int LIMIT           = 5_000_000;

    typedef struct {
        logic [tcw_pkg::POS_W-1:0]  cursor;
        logic [tcw_pkg::CELL_W-1:0] data;
        logic                       scrolled;
    } console_result_t;

    class console_scoreboard;
        logic [tcw_pkg::CELL_W-1:0]  cells [CELLS];
        bit                          written [CELLS];
        int unsigned                 cursor;
        logic [tcw_pkg::COLOR_W-1:0] fg;
        logic [tcw_pkg::COLOR_W-1:0] bg;
        console_result_t             expected_q [$];
        int                          errors;

        function new();
            cursor = 0;
            fg     = tcw_pkg::FG_RESET;
            bg     = tcw_pkg::BG_RESET;
            errors = 0;
            foreach (written[i])
            begin
                written[i] = 0;
                cells[i]   = '0;
            end
        endfunction

        function logic [tcw_pkg::CELL_W-1:0] blank_cell();
            return {bg, fg, {tcw_pkg::CHAR_W{1'b0}}};
        endfunction

        function void set_reg(tcw_pkg::cfg_reg_t which, logic [tcw_pkg::COLOR_W-1:0] value);
            case (which)
                tcw_pkg::CFG_FG: fg = value;
                tcw_pkg::CFG_BG: bg = value;
                default: ;
            endcase
        endfunction

        function void scroll_screen();
            logic [tcw_pkg::CELL_W-1:0] fill;
            fill = blank_cell();
            for (int i = 0; i < CELLS - COLS; i++)
            begin
                cells[i]   = cells[i + COLS];
                written[i] = written[i + COLS];
            end
            for (int i = CELLS - COLS; i < CELLS; i++)
            begin
                cells[i]   = fill;
                written[i] = 1;
            end
        endfunction

        // Advance the screen state by one accepted request and queue its result.
        function void note_request(tcw_pkg::req_t kind, logic [tcw_pkg::CHAR_W-1:0] ch,
                                   logic [tcw_pkg::POS_W-1:0] idx);
            console_result_t r;
            r.data     = '0;
            r.scrolled = 1'b0;
            case (kind)
                tcw_pkg::REQ_PUT:
                begin
                    if (ch == tcw_pkg::NEWLINE_CODE)
                        cursor = (cursor / COLS + 1) * COLS;
                    else
                    begin
                        if (cursor < CELLS)
                        begin
                            cells[cursor]   = {bg, fg, ch};
                            written[cursor] = 1;
                        end
                        cursor++;
                    end
                    if (cursor >= CELLS)
                    begin
                        scroll_screen();
                        cursor -= COLS;
                        r.scrolled = 1'b1;
                    end
                end
                tcw_pkg::REQ_CLEAR:
                begin
                    foreach (cells[i])
                    begin
                        cells[i]   = blank_cell();
                        written[i] = 1;
                    end
                end
                tcw_pkg::REQ_READ:
                begin
                    if (idx < CELLS)
                        r.data = cells[idx];
                end
                default: ;
            endcase
            r.cursor = tcw_pkg::POS_W'(cursor);
            expected_q.push_back(r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic [tcw_pkg::OUT_TDATA_W-1:0] word);
            console_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %h with nothing outstanding", word));
                return;
            end
            want = expected_q.pop_front();
            if (word[tcw_pkg::POS_W-1:0] !== want.cursor)
                report($sformatf("cursor_pos %0d, want %0d", word[tcw_pkg::POS_W-1:0],
                                 want.cursor));
            if (word[tcw_pkg::POS_W +: tcw_pkg::CELL_W] !== want.data)
                report($sformatf("read_data %h, want %h",
                                 word[tcw_pkg::POS_W +: tcw_pkg::CELL_W], want.data));
            if (word[tcw_pkg::POS_W + tcw_pkg::CELL_W] !== want.scrolled)
                report($sformatf("scrolled %b, want %b",
                                 word[tcw_pkg::POS_W + tcw_pkg::CELL_W], want.scrolled));
            if (word[tcw_pkg::OUT_TDATA_W-1 -: tcw_pkg::OUT_PAD_W] !== '0)
                report($sformatf("padding bits %h not zero",
                                 word[tcw_pkg::OUT_TDATA_W-1 -: tcw_pkg::OUT_PAD_W]));
        endtask
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [tcw_pkg::IN_TDATA_W-1:0]    s_axis_tdata;
    logic [tcw_pkg::REQ_W-1:0]         s_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [tcw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [0:0]                        cfg_index;
    logic [tcw_pkg::COLOR_W-1:0]       cfg_data;

    console_scoreboard sb;
    int                burst_left;
    int                hold_requests = 0;
    int                cycle_count   = 0;

    text_console_writer #(
        .COLUMNS(COLS),
        .ROWS   (ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Receiver: switches between random stall modes; long hold-offs on request.
    initial
    begin : receiver
        int mode;
        int mode_left;
        int holds_done;
        m_axis_tready = 1'b0;
        mode          = 0;
        mode_left     = 0;
        holds_done    = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_requests != holds_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = 50;
                end
                mode_left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ~m_axis_tready;
                endcase
            end
            @(posedge clk);
        end
    end

    task automatic send_item(tcw_pkg::req_t kind, logic [tcw_pkg::CHAR_W-1:0] ch,
                             logic [tcw_pkg::POS_W-1:0] idx);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{tcw_pkg::IN_PAD_W{1'b0}}, idx, ch};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(kind, ch, idx);
    endtask

    task automatic put_char(logic [tcw_pkg::CHAR_W-1:0] ch);
        send_item(tcw_pkg::REQ_PUT, ch, tcw_pkg::POS_W'($urandom));
    endtask

    // Only cells already set by a write or clear, or addresses past the screen.
    function automatic logic [tcw_pkg::POS_W-1:0] read_target();
        int unsigned pick;
        if ($urandom_range(0, 9) == 0)
            return tcw_pkg::POS_W'($urandom_range(MAX_INDEX, CELLS));
        if ($urandom_range(0, 3) == 0 && sb.cursor > 0 && sb.written[sb.cursor - 1])
            return tcw_pkg::POS_W'(sb.cursor - 1);
        repeat (8)
        begin
            pick = $urandom_range(CELLS - 1, 0);
            if (sb.written[pick])
                return tcw_pkg::POS_W'(pick);
        end
        return tcw_pkg::POS_W'($urandom_range(MAX_INDEX, CELLS));
    endfunction

    task automatic read_cell(logic [tcw_pkg::POS_W-1:0] idx);
        send_item(tcw_pkg::REQ_READ, tcw_pkg::CHAR_W'($urandom), idx);
    endtask

    function automatic logic [tcw_pkg::CHAR_W-1:0] text_char();
        if ($urandom_range(0, 11) == 0)
            return tcw_pkg::NEWLINE_CODE;
        return tcw_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic wait_drain(int settle);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_colors(logic [tcw_pkg::COLOR_W-1:0] fg_val,
                              logic [tcw_pkg::COLOR_W-1:0] bg_val);
        cfg_valid <= 1'b1;
        cfg_index <= tcw_pkg::CFG_FG;
        cfg_data  <= fg_val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(tcw_pkg::CFG_FG, fg_val);
        cfg_index <= tcw_pkg::CFG_BG;
        cfg_data  <= bg_val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(tcw_pkg::CFG_BG, bg_val);
        cfg_valid <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [tcw_pkg::COLOR_W-1:0] fg_val;
        logic [tcw_pkg::COLOR_W-1:0] bg_val;
        int                          done;
        int                          pick;
        int                          len;
        bit                          paused;
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tcw_pkg::REQ_PUT;
        cfg_valid     = 1'b0;
        cfg_index     = tcw_pkg::CFG_FG;
        cfg_data      = '0;
        burst_left    = 0;
        paused        = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset colors: character extremes, reads of written
        // cells and past the screen, the unused code, newline and clear.
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        read_cell(0);
        read_cell(1);
        read_cell(2);
        read_cell(tcw_pkg::POS_W'(MAX_INDEX));
        read_cell(tcw_pkg::POS_W'(CELLS));
        send_item(tcw_pkg::REQ_NONE, 8'hFF, tcw_pkg::POS_W'(MAX_INDEX));
        send_item(tcw_pkg::REQ_NONE, 8'h00, '0);
        put_char(tcw_pkg::NEWLINE_CODE);
        put_char(8'h09);
        put_char(8'h0B);
        read_cell(tcw_pkg::POS_W'(COLS));
        send_item(tcw_pkg::REQ_CLEAR, 8'hFF, tcw_pkg::POS_W'(MAX_INDEX));
        read_cell(0);
        read_cell(tcw_pkg::POS_W'(CELLS - 1));
        read_cell(tcw_pkg::POS_W'(COLS + 1));

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drain(4);
            case (p)
                0: begin fg_val = 4'h0; bg_val = 4'hF; end
                1: begin fg_val = 4'hF; bg_val = 4'hF; end
                2: begin fg_val = 4'h0; bg_val = 4'h0; end
                3: begin fg_val = 4'hF; bg_val = 4'h0; end
                default:
                begin
                    fg_val = tcw_pkg::COLOR_W'($urandom);
                    bg_val = tcw_pkg::COLOR_W'($urandom);
                end
            endcase
            set_colors(fg_val, bg_val);
            done = 0;

            if (p == 0)
            begin
                // Walk the cursor to the last row, then newline there to force a scroll.
                while (sb.cursor < (ROWS - 1) * COLS)
                begin
                    put_char(tcw_pkg::NEWLINE_CODE);
                    done++;
                end
                repeat (3) put_char(tcw_pkg::CHAR_W'($urandom_range(32, 126)));
                put_char(tcw_pkg::NEWLINE_CODE);
                read_cell(tcw_pkg::POS_W'(CELLS - 2 * COLS));
                done += 5;
            end
            if (p == 1)
                hold_requests++;

            while (done < ITEMS_PER_PHASE)
            begin
                if (p == 2 && !paused && done >= 50)
                begin
                    paused = 1;
                    wait_drain(0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    len = $urandom_range(1, 40);
                    repeat (len) put_char(text_char());
                    done += len;
                end
                else if (pick < 55)
                begin
                    len = $urandom_range(1, 12);
                    repeat (len) put_char(tcw_pkg::NEWLINE_CODE);
                    done += len;
                end
                else if (pick < 78)
                begin
                    len = $urandom_range(1, 6);
                    repeat (len) read_cell(read_target());
                    done += len;
                end
                else if (pick < 81)
                begin
                    send_item(tcw_pkg::REQ_CLEAR, tcw_pkg::CHAR_W'($urandom),
                              tcw_pkg::POS_W'($urandom));
                    done++;
                end
                else if (pick < 88)
                begin
                    // unused request code: no effect, not counted
                    repeat ($urandom_range(1, 3))
                        send_item(tcw_pkg::REQ_NONE, tcw_pkg::CHAR_W'($urandom),
                                  tcw_pkg::POS_W'($urandom));
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: put_char(tcw_pkg::CHAR_W'($urandom));
                        1: read_cell(read_target());
                        default: send_item(tcw_pkg::REQ_NONE, tcw_pkg::CHAR_W'($urandom),
                                           tcw_pkg::POS_W'($urandom));
                    endcase
                    done++;
                end
            end
        end

        wait_drain(20);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: text_console_writer.f
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_cursor.sv
sv/text_console_writer.sv
test/text_console_writer_tb.sv
